FILE: src/kmsd_pkg.sv
// ----------------------------------------------------------------------------
// kmsd_pkg
// Shared types and constants for the keypad matrix scanner with debounce.
// ----------------------------------------------------------------------------
`default_nettype none

package kmsd_pkg;

   localparam logic [7:0] COLUMN_MASK    = 8'hfe;
   localparam logic [7:0] ONKEY_MASK     = 8'h01;
   localparam logic [7:0] IDLE_DRIVE     = 8'hff;
   localparam logic [7:0] FIRST_DRIVE    = 8'h80;
   localparam logic [7:0] RUN_MAX        = 8'hff;
   localparam logic [7:0] DEBOUNCE_RESET = 8'd16;
   localparam int unsigned ONKEY_BIT     = 63;

   localparam logic [3:0] PHASE_FIRST    = 4'd0;

   localparam int unsigned CSR_ADDR_W    = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE_ADDR = 3'd0;

   typedef struct packed {
      logic [7:0]  column_drive;
      logic        matrix_ready;
      logic [63:0] key_matrix;
   } rsp_type;

endpackage

`default_nettype wire

FILE: src/kmsd_skid.sv
// ----------------------------------------------------------------------------
// kmsd_skid
// Two-entry result buffer: output register plus skid stage, full throughput.
// ----------------------------------------------------------------------------
`default_nettype none

module kmsd_skid (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire kmsd_pkg::rsp_type in_data,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output kmsd_pkg::rsp_type      out_data
);
   import kmsd_pkg::*;

   logic    main_valid_ff;
   logic    main_valid_in;
   rsp_type main_ff;
   rsp_type main_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_ff;
   rsp_type skid_in;
   logic    in_xfer;
   logic    out_xfer;

   assign in_stall  = skid_valid_ff;
   assign in_xfer   = in_valid && !skid_valid_ff;
   assign out_xfer  = main_valid_ff && !out_stall;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      priority if (out_xfer || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_xfer;
            main_in       = in_data;
         end
      end else if (in_xfer) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end else begin
         skid_valid_in = skid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

FILE: src/keypad_matrix_scanner_debounce.sv
// ----------------------------------------------------------------------------
// keypad_matrix_scanner_debounce
// Debounced scan of an 8-column key matrix plus on key into a 64-bit map.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    row_lines
//   rsp      out        rsp_valid/stall    column_drive, matrix_ready,
//                                          key_matrix
//   csr      in         APB write/read     debounce_count at byte 0
//
// One sample is taken every cycle while req_stall is low; its result is
// registered in the result buffer. The debounce state advances in the cycle
// of the transfer, so the rate is set by that single state update: one item per clock while not stalled.
// Reset (synchronous) restarts at column 7 and sets debounce_count to 16.
// A stalled result is held in a skid stage; req_stall rises only when both
// result slots are full.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_matrix_scanner_debounce (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_row_lines,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [7:0]                           rsp_column_drive,
   output logic                                 rsp_matrix_ready,
   output logic [63:0]                          rsp_key_matrix,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [kmsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import kmsd_pkg::*;

   logic [7:0]  debounce_ff;
   logic [7:0]  debounce_in;
   logic [3:0]  phase_ff;
   logic [3:0]  phase_in;
   logic [7:0]  run_ff;
   logic [7:0]  run_in;
   logic [7:0]  held_ff;
   logic [7:0]  held_in;
   logic [63:0] acc_ff;
   logic [63:0] acc_in;

   logic        req_xfer;
   logic        csr_write;
   logic        column;
   logic [7:0]  sample;
   logic [7:0]  run_step;
   logic        done;
   rsp_type     step_rsp;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == CSR_DEBOUNCE_ADDR) ? {24'd0, debounce_ff} : 32'd0;

   always_comb begin
      debounce_in = debounce_ff;
      if (csr_write && csr_paddr == CSR_DEBOUNCE_ADDR) begin
         debounce_in = csr_pwdata[7:0];
      end
   end

   // scan step
   assign req_xfer = req_valid && !req_stall;
   assign column   = !phase_ff[3];
   assign sample   = req_row_lines & (column ? COLUMN_MASK : ONKEY_MASK);

   always_comb begin
      if (sample == held_ff) begin
         run_step = (run_ff == RUN_MAX) ? run_ff : run_ff + 8'd1;
      end else begin
         run_step = 8'd0;
      end
      done     = run_step >= debounce_ff;
      held_in  = sample;
      run_in   = done ? 8'd0 : run_step;
      phase_in = phase_ff;
      acc_in   = acc_ff;
      step_rsp.matrix_ready = 1'b0;
      step_rsp.key_matrix   = 64'd0;
      if (done) begin
         if (column) begin
            acc_in   = {acc_ff[55:0], sample};
            phase_in = phase_ff + 4'd1;
         end else begin
            step_rsp.matrix_ready = 1'b1;
            step_rsp.key_matrix   = acc_ff;
            step_rsp.key_matrix[ONKEY_BIT] = acc_ff[ONKEY_BIT] | sample[0];
            acc_in   = 64'd0;
            phase_in = PHASE_FIRST;
         end
      end
      if (step_rsp.matrix_ready) begin
         step_rsp.column_drive = IDLE_DRIVE;
      end else if (!phase_in[3]) begin
         step_rsp.column_drive = FIRST_DRIVE >> phase_in[2:0];
      end else begin
         step_rsp.column_drive = ONKEY_MASK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         phase_ff    <= PHASE_FIRST;
         run_ff      <= 8'd0;
         held_ff     <= 8'd0;
         acc_ff      <= 64'd0;
      end else begin
         debounce_ff <= debounce_in;
         if (req_xfer) begin
            phase_ff <= phase_in;
            run_ff   <= run_in;
            held_ff  <= held_in;
            acc_ff   <= acc_in;
         end
      end
   end

   // result buffer
   rsp_type out_rsp;

   kmsd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (step_rsp),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_rsp)
   );

   assign rsp_column_drive = out_rsp.column_drive;
   assign rsp_matrix_ready = out_rsp.matrix_ready;
   assign rsp_key_matrix   = out_rsp.key_matrix;

endmodule

`default_nettype wire

FILE: tb/keypad_matrix_scanner_debounce_tb.sv
// ----------------------------------------------------------------------------
// keypad_matrix_scanner_debounce_tb
// Self-checking bench for the debounced key matrix scanner. Row samples are
// fed from a queue through a valid/stall driver with random gaps. Every
// transfer is run through a behavioural scan predictor. The results are
// compared field by field against the oldest expectation. The debounce count
// is rewritten over APB between phases while the scanner is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_matrix_scanner_debounce_tb;

   import kmsd_pkg::*;

   localparam logic [3:0] ONKEY_PHASE = 4'd8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_row_lines = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_column_drive;
   logic                  rsp_matrix_ready;
   logic [63:0]           rsp_key_matrix;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = 32'h0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // scan predictor state
   logic [7:0]  debounce_len = DEBOUNCE_RESET;
   logic [3:0]  col_phase = PHASE_FIRST;
   logic [7:0]  settle_run = 8'd0;
   logic [7:0]  latched_rows = 8'd0;
   logic [63:0] map_acc = 64'd0;

   logic [7:0]  row_queue[$];
   rsp_type     matrix_expect[$];
   int          error_count = 0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          hold_requests = 0;
   int          hold_served = 0;
   bit          req_idling = 1'b1;
   bit          rsp_idling = 1'b1;

   keypad_matrix_scanner_debounce i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_row_lines    (req_row_lines),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column_drive (rsp_column_drive),
      .rsp_matrix_ready (rsp_matrix_ready),
      .rsp_key_matrix   (rsp_key_matrix),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic rsp_type predict_scan(input logic [7:0] rows);
      rsp_type    r;
      logic       column;
      logic [7:0] sample;
      column = col_phase < ONKEY_PHASE;
      sample = rows & (column ? COLUMN_MASK : ONKEY_MASK);
      if (sample == latched_rows) begin
         if (settle_run != RUN_MAX) settle_run = settle_run + 8'd1;
      end else begin
         settle_run   = 8'd0;
         latched_rows = sample;
      end
      r.matrix_ready = 1'b0;
      r.key_matrix   = 64'd0;
      if (settle_run >= debounce_len) begin
         settle_run = 8'd0;
         if (column) begin
            map_acc   = {map_acc[55:0], latched_rows};
            col_phase = col_phase + 4'd1;
         end else begin
            r.key_matrix            = map_acc;
            r.key_matrix[ONKEY_BIT] = r.key_matrix[ONKEY_BIT] | latched_rows[0];
            r.matrix_ready          = 1'b1;
            map_acc                 = 64'd0;
            col_phase               = PHASE_FIRST;
         end
      end
      if (r.matrix_ready)
         r.column_drive = IDLE_DRIVE;
      else if (col_phase < ONKEY_PHASE)
         r.column_drive = FIRST_DRIVE >> col_phase;
      else
         r.column_drive = ONKEY_MASK;
      return r;
   endfunction

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // driver: hold the payload while stalled, advance on transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            matrix_expect.push_back(predict_scan(req_row_lines));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (row_queue.size() != 0) begin
               req_valid     <= 1'b1;
               req_row_lines <= row_queue.pop_front();
               send_gap = req_idling ? gap_length() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         stall_left = 80;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = rsp_idling ? gap_length() : 0;
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // monitor
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (matrix_expect.size() == 0) begin
            report_mismatch("unexpected result", rsp_key_matrix, 64'd0);
         end else begin
            want = matrix_expect.pop_front();
            if (rsp_column_drive !== want.column_drive)
               report_mismatch("column_drive", 64'(rsp_column_drive),
                               64'(want.column_drive));
            if (rsp_matrix_ready !== want.matrix_ready)
               report_mismatch("matrix_ready", 64'(rsp_matrix_ready),
                               64'(want.matrix_ready));
            if (rsp_key_matrix !== want.key_matrix)
               report_mismatch("key_matrix", rsp_key_matrix, want.key_matrix);
         end
      end
   end

   task automatic settle();
      @(negedge clock);
      while (row_queue.size() != 0 || req_valid || matrix_expect.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_debounce(input logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_DEBOUNCE_ADDR;
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      debounce_len = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {24'd0, value})
         report_mismatch("debounce_count readback", 64'(csr_prdata),
                         64'({24'd0, value}));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // most phases: a short bounce, then a steady reading long enough to settle
   task automatic queue_segments(input int count);
      logic [7:0] steady;
      int         pick;
      int         run;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            repeat ($urandom_range(1, 6)) row_queue.push_back(8'($urandom));
         end else begin
            repeat ($urandom_range(0, 3)) row_queue.push_back(8'($urandom));
            steady = (pick < 25) ? 8'h00 : (pick < 35) ? 8'hff : 8'($urandom);
            run = int'(debounce_len) + 1 + $urandom_range(0, 2);
            repeat (run) row_queue.push_back(steady);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      queue_segments(18);
      settle();

      write_debounce(8'd0);
      row_queue = '{8'h00, 8'hff, 8'h01, 8'hfe, 8'h80, 8'h7f, 8'h55, 8'haa, 8'h01,
                    8'hff, 8'h00, 8'h80, 8'h01, 8'hfe, 8'h3c, 8'hc3, 8'h0f, 8'hf0,
                    8'h00};
      settle();

      write_debounce(8'd1);
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      hold_requests++;
      queue_segments(135);
      settle();

      req_idling = 1'b1;
      rsp_idling = 1'b1;
      write_debounce(8'd255);
      queue_segments(3);
      settle();

      repeat (10) begin
         write_debounce(8'($urandom_range(2, 6)));
         req_idling = $urandom_range(0, 3) != 0;
         rsp_idling = $urandom_range(0, 3) != 0;
         queue_segments(9 + $urandom_range(0, 4));
         settle();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: filelist.f
src/kmsd_pkg.sv
src/kmsd_skid.sv
src/keypad_matrix_scanner_debounce.sv
tb/keypad_matrix_scanner_debounce_tb.sv
